### hdl/lexical_token_scanner_core_macros.svh
// assertion macros shared by the scanner rtl
// no dependencies; included by the modules that carry checks
`ifndef LEXICAL_TOKEN_SCANNER_CORE_MACROS_SVH
`define LEXICAL_TOKEN_SCANNER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property, checked outside reset
`define LTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lexical scanner check failed");
// same-cycle implication, checked outside reset
`define LTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexical scanner check failed");
// next-cycle implication, checked outside reset
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexical scanner check failed");
`else
`define LTS_ASSERT(label, clk, rst, prop)
`define LTS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/lts_pkg.sv
// shared types, token codes, character constants and classifiers for the scanner
// no dependencies; imported by every scanner module
package lts_pkg;

   // default sizes
   localparam int POS_BITS_DEFAULT    = 24;
   localparam int LINE_BITS_DEFAULT   = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int KIND_W = 5;
   localparam int ERR_W  = 2;

   // input commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_PLUS      = 5'd0;
   localparam logic [KIND_W-1:0] KIND_MINUS     = 5'd1;
   localparam logic [KIND_W-1:0] KIND_STAR      = 5'd2;
   localparam logic [KIND_W-1:0] KIND_SLASH     = 5'd3;
   localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd4;
   localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd5;
   localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd6;
   localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd7;
   localparam logic [KIND_W-1:0] KIND_SEMICOLON = 5'd8;
   localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd9;
   localparam logic [KIND_W-1:0] KIND_DOT       = 5'd10;
   localparam logic [KIND_W-1:0] KIND_EQUAL     = 5'd11;
   localparam logic [KIND_W-1:0] KIND_BANG      = 5'd13;
   localparam logic [KIND_W-1:0] KIND_GREATER   = 5'd15;
   localparam logic [KIND_W-1:0] KIND_LESS      = 5'd17;
   localparam logic [KIND_W-1:0] KIND_STRING    = 5'd19;
   localparam logic [KIND_W-1:0] KIND_NUMBER    = 5'd20;
   localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd21;
   localparam logic [KIND_W-1:0] KIND_ERROR     = 5'd22;
   localparam logic [KIND_W-1:0] KIND_EOF       = 5'd23;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN_CHAR = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OPEN_STRING  = 2'd2;

   // characters
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_GREATER    = 8'h3E;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;
   localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;

   // scanner modes, one-hot
   typedef enum logic [10:0] {
      MODE_IDLE     = 11'b000_0000_0001,
      MODE_SLASH    = 11'b000_0000_0010,
      MODE_EQ       = 11'b000_0000_0100,
      MODE_BANG     = 11'b000_0000_1000,
      MODE_GT       = 11'b000_0001_0000,
      MODE_LT       = 11'b000_0010_0000,
      MODE_NUM_INT  = 11'b000_0100_0000,
      MODE_NUM_FRAC = 11'b000_1000_0000,
      MODE_IDENT    = 11'b001_0000_0000,
      MODE_STRING   = 11'b010_0000_0000,
      MODE_COMMENT  = 11'b100_0000_0000
   } scan_mode_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // single-character operator lookup
   typedef struct packed {
      logic              hit;
      logic [KIND_W-1:0] kind;
   } single_op_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_word_start(input logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
   endfunction

   function automatic single_op_type single_op(input logic [7:0] c);
      single_op_type r;
      r.hit  = 1'b1;
      r.kind = KIND_PLUS;
      unique case (c)
         CH_PLUS:      r.kind = KIND_PLUS;
         CH_MINUS:     r.kind = KIND_MINUS;
         CH_STAR:      r.kind = KIND_STAR;
         CH_LPAREN:    r.kind = KIND_LPAREN;
         CH_RPAREN:    r.kind = KIND_RPAREN;
         CH_LBRACE:    r.kind = KIND_LBRACE;
         CH_RBRACE:    r.kind = KIND_RBRACE;
         CH_SEMICOLON: r.kind = KIND_SEMICOLON;
         CH_COMMA:     r.kind = KIND_COMMA;
         CH_DOT:       r.kind = KIND_DOT;
         default:      r.hit  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

### hdl/lts_front.sv
// scanner front: takes bytes, tracks mode, position and line, builds result pairs
// depends on lts_pkg and the assertion macro header
`include "lexical_token_scanner_core_macros.svh"

module lts_front import lts_pkg::*; #(
   parameter int POSITION_BITS = POS_BITS_DEFAULT,
   parameter int LINE_BITS     = LINE_BITS_DEFAULT,
   parameter int TOK_W         = KIND_W + ERR_W + 2 * POS_BITS_DEFAULT + LINE_BITS_DEFAULT,
   parameter int ENTRY_W       = 1 + 2 * TOK_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [7:0]               req_char_in,
   input  queue_status_type         q_status,
   output logic                     push_valid,
   output logic [ENTRY_W-1:0]       push_data
);

   scan_mode_type            mode_ff, mode_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;

   logic                     accept;
   logic [POSITION_BITS-1:0] nx;
   logic                     fresh;
   logic                     held_v;
   logic [KIND_W-1:0]        held_kind;
   logic [ERR_W-1:0]         held_err;
   logic [POSITION_BITS-1:0] held_end;
   logic                     new_v;
   logic [KIND_W-1:0]        new_kind;
   logic [ERR_W-1:0]         new_err;
   logic [POSITION_BITS-1:0] new_start;
   logic [POSITION_BITS-1:0] new_end;
   logic [KIND_W-1:0]        cmp_kind;
   single_op_type            op;
   logic [TOK_W-1:0]         held_tok, new_tok;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign nx        = (pos_ff == '1) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign op        = single_op(req_char_in);

   // kind of the one-character comparison held in mode
   always_comb begin
      unique case (mode_ff)
         MODE_SLASH:                  cmp_kind = KIND_SLASH;
         MODE_EQ:                     cmp_kind = KIND_EQUAL;
         MODE_BANG:                   cmp_kind = KIND_BANG;
         MODE_GT:                     cmp_kind = KIND_GREATER;
         MODE_LT:                     cmp_kind = KIND_LESS;
         MODE_NUM_INT, MODE_NUM_FRAC: cmp_kind = KIND_NUMBER;
         default:                     cmp_kind = KIND_IDENT;
      endcase
   end

   // mode update and token selection
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      fresh     = 1'b0;
      held_v    = 1'b0;
      held_kind = cmp_kind;
      held_err  = ERR_NONE;
      held_end  = pos_ff;
      new_v     = 1'b0;
      new_kind  = KIND_EOF;
      new_err   = ERR_NONE;
      new_start = pos_ff;
      new_end   = pos_ff;

      if (req_cmd == CMD_END) begin
         // flush held token, then end of file, then back to reset state
         held_v = !((mode_ff == MODE_IDLE) || (mode_ff == MODE_COMMENT));
         if (mode_ff == MODE_STRING) begin
            held_kind = KIND_ERROR;
            held_err  = ERR_OPEN_STRING;
         end
         new_v    = 1'b1;
         mode_in  = MODE_IDLE;
         start_in = '0;
         pos_in   = '0;
         line_in  = LINE_BITS'(1);
      end else begin
         pos_in = nx;
         // continue or close the held token
         unique case (mode_ff)
            MODE_IDLE: fresh = 1'b1;
            MODE_SLASH: begin
               if (req_char_in == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  held_v = 1'b1;
                  fresh  = 1'b1;
               end
            end
            MODE_EQ, MODE_BANG, MODE_GT, MODE_LT: begin
               held_v = 1'b1;
               if (req_char_in == CH_EQUAL) begin
                  held_kind = cmp_kind + KIND_W'(1);
                  held_end  = nx;
                  mode_in   = MODE_IDLE;
               end else begin
                  fresh = 1'b1;
               end
            end
            MODE_NUM_INT: begin
               if (req_char_in == CH_DOT) begin
                  mode_in = MODE_NUM_FRAC;
               end else if (!is_digit(req_char_in)) begin
                  held_v = 1'b1;
                  fresh  = 1'b1;
               end
            end
            MODE_NUM_FRAC: begin
               if (!is_digit(req_char_in)) begin
                  held_v = 1'b1;
                  fresh  = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (!is_word_start(req_char_in) && !is_digit(req_char_in)) begin
                  held_v = 1'b1;
                  fresh  = 1'b1;
               end
            end
            MODE_STRING: begin
               if (req_char_in == CH_QUOTE) begin
                  held_v    = 1'b1;
                  held_kind = KIND_STRING;
                  held_end  = nx;
                  mode_in   = MODE_IDLE;
               end
            end
            MODE_COMMENT: fresh = (req_char_in == CH_NEWLINE);
            default: fresh = 1'b1;
         endcase

         // start a new token from this byte
         if (fresh) begin
            start_in = pos_ff;
            new_end  = nx;
            mode_in  = MODE_IDLE;
            priority if (req_char_in == CH_NEWLINE) begin
               if (line_ff != '1) line_in = line_ff + LINE_BITS'(1);
            end else if (is_blank(req_char_in)) begin
               mode_in = MODE_IDLE;
            end else if (op.hit) begin
               new_v    = 1'b1;
               new_kind = op.kind;
            end else if (req_char_in == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (req_char_in == CH_EQUAL) begin
               mode_in = MODE_EQ;
            end else if (req_char_in == CH_BANG) begin
               mode_in = MODE_BANG;
            end else if (req_char_in == CH_GREATER) begin
               mode_in = MODE_GT;
            end else if (req_char_in == CH_LESS) begin
               mode_in = MODE_LT;
            end else if (req_char_in == CH_QUOTE) begin
               mode_in = MODE_STRING;
            end else if (is_digit(req_char_in)) begin
               mode_in = MODE_NUM_INT;
            end else if (is_word_start(req_char_in)) begin
               mode_in = MODE_IDENT;
            end else begin
               new_v    = 1'b1;
               new_kind = KIND_ERROR;
               new_err  = ERR_UNKNOWN_CHAR;
            end
         end
      end
   end

   // token records: kind, error, start, length, line
   assign held_tok = {held_kind, held_err, start_ff, held_end - start_ff, line_ff};
   assign new_tok  = {new_kind, new_err, new_start, new_end - new_start, line_ff};

   // first slot always filled first; flag marks a second result
   assign push_valid = accept && (held_v || new_v);
   assign push_data  = {held_v && new_v, new_tok, held_v ? held_tok : new_tok};

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= LINE_BITS'(1);
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
      end
   end

   // checks
   `LTS_ASSERT_NEXT(a_end_resets, clock, reset, accept && (req_cmd == CMD_END),
      (mode_ff == MODE_IDLE) && (pos_ff == '0) && (line_ff == LINE_BITS'(1)))
   `LTS_ASSERT_IMPL(a_start_behind, clock, reset, mode_ff != MODE_IDLE, start_ff <= pos_ff)

endmodule

### hdl/lts_queue.sv
// short queue of result pairs between the scanner front and the output back
// depends on lts_pkg and the assertion macro header
`include "lexical_token_scanner_core_macros.svh"

module lts_queue import lts_pkg::*; #(
   parameter int DEPTH   = QUEUE_DEPTH_DEFAULT,
   parameter int ENTRY_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  logic [ENTRY_W-1:0] push_data,
   input  logic               pop,
   output queue_status_type   q_status,
   output logic [ENTRY_W-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [ENTRY_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_data      = slot_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push_valid) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (pop)        rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (push_valid && !pop)      count_in = count_ff + CNT_W'(1);
      else if (!push_valid && pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_valid) slot_ff[wr_ff] <= push_data;
   end

   // checks
   `LTS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `LTS_ASSERT_IMPL(a_no_overflow, clock, reset, q_status.full && !pop, !push_valid)

endmodule

### hdl/lts_back.sv
// output back: drains result pairs from the queue, one result per transfer
// depends on lts_pkg and the assertion macro header
`include "lexical_token_scanner_core_macros.svh"

module lts_back import lts_pkg::*; #(
   parameter int POSITION_BITS = POS_BITS_DEFAULT,
   parameter int LINE_BITS     = LINE_BITS_DEFAULT,
   parameter int TOK_W         = KIND_W + ERR_W + 2 * POS_BITS_DEFAULT + LINE_BITS_DEFAULT,
   parameter int ENTRY_W       = 1 + 2 * TOK_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  queue_status_type         q_status,
   input  logic [ENTRY_W-1:0]       head_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [KIND_W-1:0]        rsp_token_kind,
   output logic [ERR_W-1:0]         rsp_error_code,
   output logic [POSITION_BITS-1:0] rsp_start_offset,
   output logic [POSITION_BITS-1:0] rsp_token_length,
   output logic [LINE_BITS-1:0]     rsp_line_number,
   output logic                     rsp_last_result
);

   logic                     rsp_valid_ff;
   logic                     half_ff;
   logic [TOK_W-1:0]         tok_ff;
   logic                     last_ff;
   logic                     advance;
   logic                     take;
   logic                     two;
   logic [TOK_W-1:0]         tok_sel;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign take    = advance && !q_status.empty;
   assign two     = head_data[ENTRY_W-1];
   assign tok_sel = half_ff ? head_data[2*TOK_W-1:TOK_W] : head_data[TOK_W-1:0];
   assign pop     = take && (!two || half_ff);

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= take;
         if (take) half_ff <= two && !half_ff;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff  <= tok_sel;
         last_ff <= !two || half_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_last_result  = last_ff;
   assign rsp_line_number  = tok_ff[LINE_BITS-1:0];
   assign rsp_token_length = tok_ff[LINE_BITS +: POSITION_BITS];
   assign rsp_start_offset = tok_ff[LINE_BITS + POSITION_BITS +: POSITION_BITS];
   assign rsp_error_code   = tok_ff[LINE_BITS + 2 * POSITION_BITS +: ERR_W];
   assign rsp_token_kind   = tok_ff[TOK_W-1 -: KIND_W];

   // checks
   `LTS_ASSERT_NEXT(a_pair_follows, clock, reset,
      rsp_valid_ff && !rsp_stall && !last_ff, rsp_valid_ff && last_ff)
   `LTS_ASSERT_IMPL(a_half_needs_entry, clock, reset, half_ff, !q_status.empty)

endmodule

### hdl/lexical_token_scanner_core.sv
// Lexical token scanner. Source bytes (req_cmd = 0) and an end marker
// (req_cmd = 1) enter on the req_ channel, at most one transfer per cycle;
// tokens leave on the rsp_ channel, one per transfer, with rsp_last_result
// set on the final token caused by an input. An input gives zero, one or two
// tokens. The scanner front updates its mode, position and line counters in
// the cycle a byte is taken, so input runs at one byte per cycle for as long
// as the result queue (QUEUE_DEPTH pairs) has room; the output back moves one
// token per cycle while rsp_stall is low, so an input that yields two tokens
// holds the result port for both of them, and each token passes through the
// result queue and the output register. Position and line counts saturate;
// after the end marker the front's mode, position and line return to reset.
// depends on lts_pkg and the front, queue and back modules

module lexical_token_scanner_core import lts_pkg::*; #(
   parameter int POSITION_BITS = POS_BITS_DEFAULT,
   parameter int LINE_BITS     = LINE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [7:0]               req_char_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [KIND_W-1:0]        rsp_token_kind,
   output logic [ERR_W-1:0]         rsp_error_code,
   output logic [POSITION_BITS-1:0] rsp_start_offset,
   output logic [POSITION_BITS-1:0] rsp_token_length,
   output logic [LINE_BITS-1:0]     rsp_line_number,
   output logic                     rsp_last_result
);

   localparam int TOK_W   = KIND_W + ERR_W + 2 * POSITION_BITS + LINE_BITS;
   localparam int ENTRY_W = 1 + 2 * TOK_W;

   queue_status_type   q_status;
   logic               push_valid;
   logic [ENTRY_W-1:0] push_data;
   logic               pop;
   logic [ENTRY_W-1:0] head_data;

   // byte scanning
   lts_front #(
      .POSITION_BITS (POSITION_BITS),
      .LINE_BITS     (LINE_BITS),
      .TOK_W         (TOK_W),
      .ENTRY_W       (ENTRY_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_char_in (req_char_in),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   // result pair queue
   lts_queue #(
      .DEPTH   (QUEUE_DEPTH),
      .ENTRY_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .q_status   (q_status),
      .head_data  (head_data)
   );

   // token output
   lts_back #(
      .POSITION_BITS (POSITION_BITS),
      .LINE_BITS     (LINE_BITS),
      .TOK_W         (TOK_W),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_last_result  (rsp_last_result)
   );

endmodule
